FILE: hdl/sveg_pkg.sv
`timescale 1ns / 1ps

package sveg_pkg;

  // Default values for the top-level parameters.
  localparam int RATE_HZ_DEF    = 48000;
  localparam int TIME_BITS_DEF  = 24;
  localparam int SINE_DEPTH_DEF = 256;

  // Configuration port shape.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVEFORM = 3'd0,
    REG_VOLUME   = 3'd1,
    REG_ENV_MODE = 3'd2,
    REG_ATTACK   = 3'd3,
    REG_DECAY    = 3'd4,
    REG_SUSTAIN  = 3'd5,
    REG_RELEASE  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    WAVE_SAW    = 3'd0,
    WAVE_TRI    = 3'd1,
    WAVE_SINE   = 3'd2,
    WAVE_SQUARE = 3'd3,
    WAVE_NOISE  = 3'd4
  } wave_t;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Reset values of the registers.
  localparam logic [15:0] VOLUME_RST  = 16'd16384;
  localparam logic [15:0] SUSTAIN_RST = 16'd32768;

  // 48-bit linear congruential noise source.
  localparam int          LCG_STEPS = 35;
  localparam logic [34:0] LCG_MUL   = 35'h5DEECE66D;
  localparam logic [47:0] LCG_ADD   = 48'hB;
  localparam logic [47:0] LCG_SEED  = 48'h1234ABCD330E;

  // Serial divider: the quotient always fits in 17 bits.
  localparam int DIV_QW  = 17;
  localparam int DIV_VW  = 24;
  localparam int DIV_DW  = DIV_QW + DIV_VW;

  localparam logic [63:0] ONE_Q30     = 64'h4000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic        cmd;
    logic [15:0] note_pitch;
    logic [23:0] note_length;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               voice_active;
  } out_word_t;

  // Quarter-wave sine entry for an angle x in Q30 radians, from a Taylor series.
  function automatic logic [15:0] sine_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] e;
    x2   = (x * x) >> 30;
    term = ONE_Q30 - x2 / 64'd110;
    term = ONE_Q30 - ((x2 * term) >> 30) / 64'd72;
    term = ONE_Q30 - ((x2 * term) >> 30) / 64'd42;
    term = ONE_Q30 - ((x2 * term) >> 30) / 64'd20;
    term = ONE_Q30 - ((x2 * term) >> 30) / 64'd6;
    s    = (x * term) >> 30;
    e    = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    return (e > 64'd32767) ? 16'h7FFF : e[15:0];
  endfunction

endpackage

FILE: hdl/synth_voice_envelope_generator_top.sv
// A start word reduces the pitch step below the sample rate by repeated subtraction. A tick
// word of an active voice gets its wave from a serial divider (saw, triangle, sine) or the LCG
// (noise), square needing neither, then a second divider for the envelope unless the gain is
// flat, then the serial multiply and round; an idle tick goes straight to the output.
// Throughput: one word in flight at a time; a stalled output holds off the next input word.
// Reset (synchronous, rst_n low): registers take defaults, the voice idles, the LCG is reseeded.
`timescale 1ns / 1ps

module synth_voice_envelope_generator_top #(
  parameter int RATE_HZ          = sveg_pkg::RATE_HZ_DEF,
  parameter int TIME_BITS        = sveg_pkg::TIME_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = sveg_pkg::SINE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sveg_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sveg_pkg::out_word_t              out_data,
  input  logic                             cfg_we,
  input  logic [sveg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sveg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sveg_pkg::*;

  // Time compares are done one bit wider than the widest operand so sums never wrap.
  localparam int EW        = ((TIME_BITS > 24) ? TIME_BITS : 24) + 1;
  localparam int FADE_LEN  = RATE_HZ / 100;
  localparam int SINE_MULT = 4 * SINE_TABLE_DEPTH;
  localparam int AW        = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [48:0] ROUND_HALF = 49'h2000_0000;

  // The sequencer walks each active-voice tick through wave, envelope, multiply and rounding.
  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_MODP = 12'b0000_0000_0010,
    ST_WSET = 12'b0000_0000_0100,
    ST_LCG  = 12'b0000_0000_1000,
    ST_DIVW = 12'b0000_0001_0000,
    ST_WMAP = 12'b0000_0010_0000,
    ST_SINE = 12'b0000_0100_0000,
    ST_ENV  = 12'b0000_1000_0000,
    ST_DIVG = 12'b0001_0000_0000,
    ST_MUL  = 12'b0010_0000_0000,
    ST_ACC  = 12'b0100_0000_0000,
    ST_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [2:0]  wave_r;
  logic [15:0] vol_r;
  logic        mode_r;
  logic [23:0] att_r;
  logic [23:0] dec_r;
  logic [15:0] sus_r;
  logic [23:0] rel_r;

  // Voice state.
  logic                 playing_r;
  logic [TIME_BITS-1:0] count_r;
  logic [TIME_BITS-1:0] end_r;
  logic [16:0]          phase_r;
  logic [16:0]          pstep_r;
  logic [47:0]          lcg_r;

  // Serial datapath.
  logic [DIV_VW-1:0] rem_r;
  logic [DIV_QW-1:0] low_r;
  logic [DIV_VW-1:0] dvs_r;
  logic [DIV_QW-1:0] quo_r;
  logic [5:0]        cnt_r;
  logic [47:0]       acc_r;
  logic [47:0]       sh_r;
  logic [34:0]       ms_r;
  logic [16:0]       gs_r;
  logic              ginv_r;
  logic signed [15:0] w_r;
  logic              sneg_r;
  logic [15:0]       rom_q_r;
  out_word_t         res_r;
  out_word_t         out_data_r;
  logic              out_valid_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Quarter-wave sine table, built at elaboration and read through a register.
  logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_sine
    localparam logic [63:0] XQ = (HALF_PI_Q30 * 64'(gi)) / 64'(SINE_TABLE_DEPTH);
    assign sine_rom[gi] = sine_entry(XQ);
  end

  // Sine address: quadrant and offset from the wave quotient.
  logic [1:0]    sine_q;
  logic [AW-1:0] sine_off;
  logic [AW-1:0] sine_addr;

  assign sine_q    = 2'(quo_r / SINE_TABLE_DEPTH);
  assign sine_off  = AW'(quo_r % SINE_TABLE_DEPTH);
  assign sine_addr = sine_q[0] ? (AW'(SINE_TABLE_DEPTH) - sine_off) : sine_off;

  always_ff @(posedge clk) begin
    rom_q_r <= sine_rom[sine_addr];
  end

  // Wave dividend: the phase scaled for saw, triangle or sine.
  logic [DIV_DW-1:0] wave_dvd;

  always_comb begin
    case (wave_r)
      WAVE_SAW: wave_dvd = DIV_DW'(phase_r) << 16;
      WAVE_TRI: wave_dvd = DIV_DW'(phase_r) << 17;
      default:  wave_dvd = DIV_DW'(phase_r) * DIV_DW'(SINE_MULT);
    endcase
  end

  // Triangle folding of the quotient.
  logic [15:0] tri_w;

  always_comb begin
    if (quo_r < 17'd32768) begin
      tri_w = quo_r[15:0];
    end else if (quo_r <= 17'd98304) begin
      tri_w = (quo_r == 17'd32768) ? 16'h7FFF : 16'(17'h10000 - quo_r);
    end else begin
      tri_w = quo_r[15:0];
    end
  end

  // One restoring division step per cycle.
  logic [DIV_VW:0]   div_trial;
  logic              div_ge;
  logic [DIV_VW-1:0] div_rem_nxt;

  assign div_trial   = {rem_r, low_r[DIV_QW-1]};
  assign div_ge      = (div_trial >= {1'b0, dvs_r});
  assign div_rem_nxt = div_ge ? DIV_VW'(div_trial - {1'b0, dvs_r}) : div_trial[DIV_VW-1:0];

  // Envelope segment selection.
  logic [EW-1:0]     tx;
  logic [EW-1:0]     ex;
  logic [EW-1:0]     ax;
  logic [EW-1:0]     dx;
  logic [EW-1:0]     rx;
  logic [23:0]       t_minus_a;
  logic [23:0]       e_minus_t;
  logic [16:0]       sus_inv;
  logic [DIV_DW-1:0] dec_prod;
  logic [DIV_DW-1:0] rel_prod;
  logic              env_div;
  logic              env_inv;
  logic              env_stop;
  logic [DIV_DW-1:0] env_dvd;
  logic [DIV_VW-1:0] env_dvs;
  logic [16:0]       env_gain;

  assign tx        = EW'(count_r);
  assign ex        = EW'(end_r);
  assign ax        = EW'(att_r);
  assign dx        = EW'(dec_r);
  assign rx        = EW'(rel_r);
  assign t_minus_a = 24'(tx - ax);
  assign e_minus_t = 24'(ex - tx);
  assign sus_inv   = 17'h10000 - {1'b0, sus_r};
  assign dec_prod  = t_minus_a * sus_inv;
  assign rel_prod  = e_minus_t * sus_r;

  always_comb begin
    env_div  = 1'b0;
    env_inv  = 1'b0;
    env_stop = 1'b0;
    env_dvd  = DIV_DW'(tx) << 16;
    env_dvs  = att_r;
    env_gain = '0;
    if (mode_r) begin
      if (tx < ax) begin
        env_div = 1'b1;
      end else if (tx < ax + dx) begin
        env_div = 1'b1;
        env_inv = 1'b1;
        env_dvd = dec_prod;
        env_dvs = dec_r;
      end else if (tx + rx < ex) begin
        env_gain = {1'b0, sus_r};
      end else if (tx < ex) begin
        env_div = 1'b1;
        env_dvd = rel_prod;
        env_dvs = rel_r;
      end else begin
        env_stop = 1'b1;
      end
    end else begin
      env_dvs = DIV_VW'(FADE_LEN);
      if (tx < EW'(FADE_LEN)) begin
        env_div = 1'b1;
      end else if (tx + EW'(FADE_LEN) < ex) begin
        env_gain = 17'h10000;
      end else if (tx < ex) begin
        env_div = 1'b1;
        env_dvd = DIV_DW'(e_minus_t) << 16;
      end else begin
        env_stop = 1'b1;
      end
    end
  end

  // Shared shift-and-add adder for the LCG and for the gain multiply.
  logic        add_en;
  logic [47:0] acc_sum;
  logic [15:0] w_u;
  logic [15:0] w_mag;
  logic [31:0] mag_vol;

  assign add_en  = (state_r == ST_LCG) ? ms_r[0] : gs_r[0];
  assign acc_sum = acc_r + (add_en ? sh_r : 48'd0);
  assign w_u     = w_r;
  assign w_mag   = w_u[15] ? 16'(~w_u + 16'd1) : w_u;
  assign mag_vol = w_mag * vol_r;

  // Rounding to nearest (ties away from zero) and saturation to Q1.15.
  logic [48:0] rnd_sum;
  logic [18:0] rnd_q;
  logic [18:0] rnd_sat;
  logic [15:0] rnd_sample;

  assign rnd_sum = 49'(acc_r) + ROUND_HALF;
  assign rnd_q   = rnd_sum[48:30];

  always_comb begin
    if (w_r[15]) begin
      rnd_sat    = (rnd_q > 19'd32768) ? 19'd32768 : rnd_q;
      rnd_sample = 16'(19'd0 - rnd_sat);
    end else begin
      rnd_sat    = (rnd_q > 19'd32767) ? 19'd32767 : rnd_q;
      rnd_sample = rnd_sat[15:0];
    end
  end

  // Phase advance, wrapped once at the sample rate.
  logic [17:0] psum;
  logic [16:0] phase_nxt;

  assign psum      = 18'(phase_r) + 18'(pstep_r);
  assign phase_nxt = (psum >= 18'(RATE_HZ)) ? 17'(psum - 18'(RATE_HZ)) : psum[16:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      wave_r      <= WAVE_SAW;
      vol_r       <= VOLUME_RST;
      mode_r      <= 1'b0;
      att_r       <= '0;
      dec_r       <= '0;
      sus_r       <= SUSTAIN_RST;
      rel_r       <= '0;
      playing_r   <= 1'b0;
      count_r     <= '0;
      end_r       <= '0;
      phase_r     <= '0;
      pstep_r     <= '0;
      lcg_r       <= LCG_SEED;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WAVEFORM: wave_r <= cfg_data[2:0];
          REG_VOLUME:   vol_r  <= cfg_data[15:0];
          REG_ENV_MODE: mode_r <= cfg_data[0];
          REG_ATTACK:   att_r  <= cfg_data;
          REG_DECAY:    dec_r  <= cfg_data;
          REG_SUSTAIN:  sus_r  <= cfg_data[15:0];
          REG_RELEASE:  rel_r  <= cfg_data;
          default: ;
        endcase
      end

      // The finishing state reloads the output register itself.
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.cmd == CMD_START) begin
              playing_r          <= 1'b1;
              count_r            <= '0;
              phase_r            <= '0;
              end_r              <= TIME_BITS'(in_data.note_length);
              pstep_r            <= 17'(in_data.note_pitch);
              res_r.sample       <= '0;
              res_r.voice_active <= 1'b1;
              state_r            <= ST_MODP;
            end else if (!playing_r) begin
              res_r.sample       <= '0;
              res_r.voice_active <= 1'b0;
              state_r            <= ST_FIN;
            end else begin
              state_r <= ST_WSET;
            end
          end
        end
        ST_MODP: begin
          if (pstep_r >= 17'(RATE_HZ)) begin
            pstep_r <= pstep_r - 17'(RATE_HZ);
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_WSET: begin
          cnt_r <= '0;
          case (wave_r)
            WAVE_SAW, WAVE_TRI, WAVE_SINE: begin
              rem_r   <= wave_dvd[DIV_DW-1:DIV_QW];
              low_r   <= wave_dvd[DIV_QW-1:0];
              dvs_r   <= DIV_VW'(RATE_HZ);
              quo_r   <= '0;
              state_r <= ST_DIVW;
            end
            WAVE_SQUARE: begin
              w_r     <= ({phase_r, 1'b0} < 18'(RATE_HZ)) ? 16'sh8000 : 16'sh7FFF;
              state_r <= ST_ENV;
            end
            WAVE_NOISE: begin
              acc_r   <= LCG_ADD;
              sh_r    <= lcg_r;
              ms_r    <= LCG_MUL;
              state_r <= ST_LCG;
            end
            default: begin
              w_r     <= '0;
              state_r <= ST_ENV;
            end
          endcase
        end
        ST_LCG: begin
          acc_r <= acc_sum;
          sh_r  <= sh_r << 1;
          ms_r  <= ms_r >> 1;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(LCG_STEPS - 1)) begin
            state_r <= ST_WMAP;
          end
        end
        ST_DIVW, ST_DIVG: begin
          rem_r <= div_rem_nxt;
          low_r <= low_r << 1;
          quo_r <= {quo_r[DIV_QW-2:0], div_ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(DIV_QW - 1)) begin
            state_r <= (state_r == ST_DIVW) ? ST_WMAP : ST_MUL;
          end
        end
        ST_WMAP: begin
          state_r <= ST_ENV;
          case (wave_r)
            WAVE_SAW: w_r <= {~quo_r[15], quo_r[14:0]};
            WAVE_TRI: w_r <= tri_w;
            WAVE_SINE: begin
              sneg_r  <= sine_q[1];
              state_r <= ST_SINE;
            end
            WAVE_NOISE: begin
              lcg_r <= acc_r;
              w_r   <= {~acc_r[47], acc_r[46:32]};
            end
            default: w_r <= '0;
          endcase
        end
        ST_SINE: begin
          w_r     <= sneg_r ? 16'(16'd0 - rom_q_r) : rom_q_r;
          state_r <= ST_ENV;
        end
        ST_ENV: begin
          ginv_r <= env_inv;
          cnt_r  <= '0;
          if (env_stop) begin
            playing_r <= 1'b0;
          end
          if (env_div) begin
            rem_r   <= env_dvd[DIV_DW-1:DIV_QW];
            low_r   <= env_dvd[DIV_QW-1:0];
            dvs_r   <= env_dvs;
            quo_r   <= '0;
            state_r <= ST_DIVG;
          end else begin
            quo_r   <= env_gain;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          sh_r    <= 48'(mag_vol);
          gs_r    <= ginv_r ? (17'h10000 - quo_r) : quo_r;
          acc_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(DIV_QW)) begin
            // All gain bits are in; round, and advance the voice.
            res_r.sample       <= rnd_sample;
            res_r.voice_active <= playing_r;
            phase_r            <= phase_nxt;
            count_r            <= count_r + TIME_BITS'(1);
            state_r            <= ST_FIN;
          end else begin
            acc_r <= acc_sum;
            sh_r  <= sh_r << 1;
            gs_r  <= gs_r >> 1;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_start_plays: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.cmd == CMD_START) |=> playing_r)
    else $error("voice not active after a start word");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r < 17'(RATE_HZ))
    else $error("phase accumulator reached the sample rate");

  a_idle_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.cmd == CMD_TICK && !playing_r) |=> $stable(count_r))
    else $error("sample counter moved on a tick of an idle voice");

  a_silent_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.voice_active) |-> (out_data_r.sample == 16'sd0))
    else $error("inactive voice gave a nonzero sample");

  a_pitch_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (pstep_r < 17'(RATE_HZ)))
    else $error("pitch step not reduced below the sample rate");

endmodule

FILE: dv/tb_synth_voice_envelope_generator_top.sv
`timescale 1ns / 1ps

module tb_synth_voice_envelope_generator_top;
  import sveg_pkg::*;

  localparam int RATE = 48000;
  localparam int DEPTH = 256;
  localparam int FADE = RATE / 100;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  synth_voice_envelope_generator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the configuration registers.
  bit [2:0] wave_sel;
  bit [15:0] vol_gain;
  bit env_adsr;
  bit [23:0] atk_len, dec_len, rel_len;
  bit [15:0] sus_gain;

  // Shadow copy of the voice state.
  bit sounding;
  bit [23:0] elapsed, note_end;
  bit [16:0] phase, phase_inc;
  bit [47:0] noise_state;
  bit [15:0] sine_quarter[0:DEPTH];

  out_word_t samples_due[$];
  int errors = 0;
  bit calm = 1'b0;
  int cycles = 0;

  // The quarter sine table, built from an eleventh-order Taylor series in Q30.
  function automatic void fill_sine();
    longint unsigned x, x2, term, s, e;
    for (int i = 0; i <= DEPTH; i++) begin
      x = (64'd1686629713 * i) / DEPTH;
      x2 = (x * x) >> 30;
      term = (64'd1 << 30) - x2 / 110;
      term = (64'd1 << 30) - ((x2 * term) >> 30) / 72;
      term = (64'd1 << 30) - ((x2 * term) >> 30) / 42;
      term = (64'd1 << 30) - ((x2 * term) >> 30) / 20;
      term = (64'd1 << 30) - ((x2 * term) >> 30) / 6;
      s = (x * term) >> 30;
      e = (s * 32767 + (64'd1 << 29)) >> 30;
      sine_quarter[i] = (e > 32767) ? 16'h7FFF : e[15:0];
    end
  endfunction

  function automatic void voice_defaults();
    wave_sel = WAVE_SAW; vol_gain = VOLUME_RST; env_adsr = 1'b0;
    atk_len = '0; dec_len = '0; rel_len = '0; sus_gain = SUSTAIN_RST;
    sounding = 1'b0; elapsed = '0; note_end = '0; phase = '0; phase_inc = '0;
    noise_state = LCG_SEED;
  endfunction

  // Waveform value in Q1.15 at phase pt; noise advances its generator.
  function automatic longint osc_value(longint unsigned pt);
    longint u;
    longint unsigned idx, q, r;
    case (wave_sel)
      WAVE_SAW: return longint'((pt * 65536) / RATE) - 32768;
      WAVE_TRI: begin
        u = longint'((pt * 131072) / RATE);
        if (u < 32768) return u;
        if (u <= 98304) return (65536 - u > 32767) ? 32767 : 65536 - u;
        return u - 131072;
      end
      WAVE_SINE: begin
        idx = (pt * 4 * DEPTH) / RATE;
        q = (idx / DEPTH) & 3;
        r = idx % DEPTH;
        case (q)
          0: return sine_quarter[r];
          1: return sine_quarter[DEPTH - r];
          2: return -longint'(sine_quarter[r]);
          default: return -longint'(sine_quarter[DEPTH - r]);
        endcase
      end
      WAVE_SQUARE: return (pt * 2 < RATE) ? -32768 : 32767;
      WAVE_NOISE: begin
        noise_state = noise_state * 48'h5DEECE66D + 48'hB;
        return longint'(noise_state[47:32]) - 32768;
      end
      default: return 0;
    endcase
  endfunction

  // Envelope gain in Q16; the voice falls silent once the note has run out.
  function automatic longint unsigned env_level();
    longint unsigned t, e, a, d, s, r;
    t = elapsed; e = note_end; a = atk_len; d = dec_len; s = sus_gain; r = rel_len;
    if (env_adsr) begin
      if (t < a) return (t * 65536) / a;
      if (t < a + d) return 65536 - ((t - a) * (65536 - s)) / d;
      if (t + r < e) return s;
      if (t < e) return (s * (e - t)) / r;
    end else begin
      if (t < FADE) return (t * 65536) / FADE;
      if (t + FADE < e) return 65536;
      if (t < e) return ((e - t) * 65536) / FADE;
    end
    sounding = 1'b0;
    return 0;
  endfunction

  function automatic out_word_t voice_step(in_word_t w);
    out_word_t res;
    longint wv, prod;
    longint unsigned g, mag, rnd;
    res.sample = '0;
    if (w.cmd == CMD_START) begin
      elapsed = '0; phase = '0; sounding = 1'b1;
      note_end = w.note_length;
      phase_inc = w.note_pitch % RATE;
    end else if (sounding) begin
      wv = osc_value(phase);
      g = env_level();
      prod = wv * longint'(vol_gain) * longint'(g);
      mag = (prod < 0) ? longint'(-prod) : longint'(prod);
      rnd = (mag + (64'd1 << 29)) >> 30;
      if (prod < 0) res.sample = (rnd > 32768) ? -16'sd32768 : -$signed(rnd[16:0]);
      else res.sample = (rnd > 32767) ? 16'sd32767 : rnd[15:0];
      phase = phase + phase_inc;
      if (phase >= RATE) phase = phase - RATE;
      elapsed = elapsed + 1'b1;
    end
    res.voice_active = sounding;
    return res;
  endfunction

  // Drive one word, honoring a random gap; the word counts at the accepting edge.
  // When a fixed expectation is given it is queued instead of the predicted one.
  task automatic send_word(in_word_t w, bit known = 1'b0, out_word_t fixed = '0);
    int gap;
    out_word_t predicted;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    predicted = voice_step(w);
    samples_due.push_back(known ? fixed : predicted);
  endtask

  task automatic drain();
    while (samples_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      REG_WAVEFORM: wave_sel = val[2:0];
      REG_VOLUME: vol_gain = val[15:0];
      REG_ENV_MODE: env_adsr = val[0];
      REG_ATTACK: atk_len = val[23:0];
      REG_DECAY: dec_len = val[23:0];
      REG_SUSTAIN: sus_gain = val[15:0];
      REG_RELEASE: rel_len = val[23:0];
      default: ;
    endcase
  endtask

  function automatic in_word_t make_word(bit c, int unsigned p, int unsigned l);
    in_word_t w;
    w.cmd = c;
    w.note_pitch = p[15:0];
    w.note_length = l[23:0];
    return w;
  endfunction

  // Unless calm is set, the receiver stalls for a random number of cycles before every word.
  initial begin
    int stall;
    out_ready <= 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Every word taken from the block is held against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (samples_due.size() == 0) begin
        $display("%0t: unexpected word: sample %0d active %0b", $time,
                 out_data.sample, out_data.voice_active);
        errors++;
      end else begin
        want = samples_due.pop_front();
        if (out_data.sample !== want.sample) begin
          $display("%0t: sample expected %0d actual %0d", $time, want.sample,
                   out_data.sample);
          errors++;
        end
        if (out_data.voice_active !== want.voice_active) begin
          $display("%0t: voice_active expected %0b actual %0b", $time,
                   want.voice_active, out_data.voice_active);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("synth_voice_envelope_generator_top: mismatch");
      $finish;
    end
  end

  typedef struct {
    bit c;
    int unsigned pitch;
    int unsigned len;
    bit known;
    logic signed [15:0] smp;
    bit act;
  } opening_row_t;

  // Opening rows under the reset configuration (saw wave, unit volume, fade envelope).
  // Expected words are typed in where they are plain: an idle tick, and any start.
  opening_row_t opening[] = '{
    '{CMD_TICK, 0, 0, 1, 0, 0},               // tick while idle
    '{CMD_START, 0, 0, 1, 0, 1},              // zero pitch, zero length
    '{CMD_TICK, 0, 0, 0, 0, 0},
    '{CMD_TICK, 65535, 24'hFFFFFF, 0, 0, 0},  // tick ignores the note fields
    '{CMD_START, 65535, 24'hFFFFFF, 1, 0, 1}, // pitch above the rate, longest note
    '{CMD_TICK, 0, 0, 0, 0, 0},
    '{CMD_TICK, 0, 0, 0, 0, 0},
    '{CMD_TICK, 0, 0, 0, 0, 0},
    '{CMD_START, 48000, 5, 1, 0, 1},          // pitch exactly at the rate
    '{CMD_TICK, 0, 0, 0, 0, 0},
    '{CMD_TICK, 0, 0, 0, 0, 0},
    '{CMD_START, 24000, 1000, 1, 0, 1},       // restart while sounding
    '{CMD_TICK, 0, 0, 0, 0, 0},
    '{CMD_TICK, 0, 0, 0, 0, 0},
    '{CMD_TICK, 0, 0, 0, 0, 0},
    '{CMD_START, 47999, 3, 1, 0, 1},          // fade longer than the note
    '{CMD_TICK, 0, 0, 0, 0, 0},
    '{CMD_TICK, 0, 0, 0, 0, 0},
    '{CMD_TICK, 0, 0, 0, 0, 0}
  };

  initial begin
    int unsigned pitch, len;
    int ticks;
    int budget;
    out_word_t fixed;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    fill_sine();
    voice_defaults();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i]) begin
      fixed.sample = opening[i].smp;
      fixed.voice_active = opening[i].act;
      send_word(make_word(opening[i].c, opening[i].pitch, opening[i].len),
                opening[i].known, fixed);
    end

    // Each phase sets a new configuration, with no word in flight, and then plays notes.
    // Phase index picks the waveform, so the three unused codes are covered too.
    for (int ph = 0; ph < 8; ph++) begin
      in_valid <= 1'b0;
      drain();
      calm = (ph == 3);
      write_reg(REG_WAVEFORM, ph);
      case (ph)
        0: write_reg(REG_VOLUME, 65535);
        1: write_reg(REG_VOLUME, 0);
        2: write_reg(REG_VOLUME, 16384);
        default: write_reg(REG_VOLUME, $urandom_range(0, 65535));
      endcase
      write_reg(REG_ENV_MODE, (ph % 3) != 0);
      write_reg(REG_ATTACK, (ph == 5) ? 24'hFFFFFF : $urandom_range(0, 20));
      write_reg(REG_DECAY, (ph == 6) ? 24'hFFFFFF : $urandom_range(0, 20));
      case (ph)
        1: write_reg(REG_SUSTAIN, 1);
        4: write_reg(REG_SUSTAIN, 65535);
        default: write_reg(REG_SUSTAIN, $urandom_range(1, 65535));
      endcase
      write_reg(REG_RELEASE, (ph == 7) ? 24'hFFFFFF : $urandom_range(0, 30));
      cfg_we <= 1'b0;

      budget = 140;
      while (budget > 0) begin
        // Mostly in-range pitches and short notes, so that notes run out often.
        pitch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, RATE - 1);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                            : $urandom_range(0, env_adsr ? 60 : 600);
        ticks = (!env_adsr && $urandom_range(0, 3) == 0) ? $urandom_range(400, 640)
                                                          : $urandom_range(1, 60);
        // A stray tick now and then before the note starts.
        if ($urandom_range(0, 4) == 0) begin
          send_word(make_word(CMD_TICK, $urandom_range(0, 65535),
                              $urandom_range(0, 24'hFFFFFF)));
          budget--;
        end
        send_word(make_word(CMD_START, pitch, len));
        budget--;
        for (int k = 0; k < ticks && budget > 0; k++) begin
          if ($urandom_range(0, 199) == 0) begin
            // Hold the sender until the block has delivered everything.
            in_valid <= 1'b0;
            while (samples_due.size() != 0) @(posedge clk);
          end
          send_word(make_word(CMD_TICK, $urandom_range(0, 65535),
                              $urandom_range(0, 24'hFFFFFF)));
          budget--;
        end
      end
    end

    in_valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("synth_voice_envelope_generator_top: match");
    end else begin
      $display("synth_voice_envelope_generator_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: synth_voice_envelope_generator_top.f
hdl/sveg_pkg.sv
hdl/synth_voice_envelope_generator_top.sv
dv/tb_synth_voice_envelope_generator_top.sv
